FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion of an implication property, disabled while in reset.
`define RLP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// A stalled transfer keeps valid high and its payload unchanged.
`define RLP_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rstn) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("%m: stalled transfer changed");

`endif

FILE: hw/rtl/rlp_pkg.sv
package rlp_pkg;

    // Default number of big-endian length bytes kept by the length accumulator.
    localparam int MAX_LENGTH_BYTES_DEF = 8;

    // Header code boundaries.
    localparam logic [7:0] HDR_SHORT_STR  = 8'h80;
    localparam logic [7:0] HDR_LONG_STR_B = 8'hB7;
    localparam logic [7:0] HDR_LONG_STR   = 8'hB8;
    localparam logic [7:0] HDR_SHORT_LIST = 8'hC0;
    localparam logic [7:0] HDR_LONG_LIST_B = 8'hF7;
    localparam logic [7:0] HDR_LONG_LIST  = 8'hF8;

    // Byte roles.
    localparam logic [2:0] ROLE_OUTER   = 3'd0;
    localparam logic [2:0] ROLE_HEADER  = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_LIST    = 3'd4;

    // Element kinds.
    localparam logic [2:0] KIND_SINGLE     = 3'd0;
    localparam logic [2:0] KIND_SHORT_STR  = 3'd1;
    localparam logic [2:0] KIND_LONG_STR   = 3'd2;
    localparam logic [2:0] KIND_SHORT_LIST = 3'd3;
    localparam logic [2:0] KIND_LONG_LIST  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_role;
        logic [2:0] element_kind;
        logic       is_list;
        logic       element_end;
        logic       malformed;
        logic       message_end;
    } out_item_t;

    // Classification of one element header byte.
    typedef struct packed {
        logic [2:0] kind;
        logic       is_single;
        logic       is_long;
        logic       is_list;
        logic [3:0] len_count;
        logic [5:0] short_len;
    } hdr_info_t;

endpackage

FILE: hw/rtl/rlp_hdr_decode.sv
module rlp_hdr_decode
    import rlp_pkg::*;
(
    input  logic [7:0] hdr_byte,
    output hdr_info_t  hdr_info
);

    logic [7:0] str_off;
    logic [7:0] list_off;
    logic [7:0] str_cnt;
    logic [7:0] list_cnt;

    assign str_off  = hdr_byte - HDR_SHORT_STR;
    assign list_off = hdr_byte - HDR_SHORT_LIST;
    assign str_cnt  = hdr_byte - HDR_LONG_STR_B;
    assign list_cnt = hdr_byte - HDR_LONG_LIST_B;

    always_comb begin
        hdr_info = '0;
        case (hdr_byte) inside
            [8'h00:8'h7F]: begin
                hdr_info.kind      = KIND_SINGLE;
                hdr_info.is_single = 1'b1;
            end
            [8'h80:8'hB7]: begin
                hdr_info.kind      = KIND_SHORT_STR;
                hdr_info.short_len = str_off[5:0];
            end
            [8'hB8:8'hBF]: begin
                hdr_info.kind      = KIND_LONG_STR;
                hdr_info.is_long   = 1'b1;
                hdr_info.len_count = str_cnt[3:0];
            end
            [8'hC0:8'hF7]: begin
                hdr_info.kind      = KIND_SHORT_LIST;
                hdr_info.is_list   = 1'b1;
                hdr_info.short_len = list_off[5:0];
            end
            default: begin
                hdr_info.kind      = KIND_LONG_LIST;
                hdr_info.is_list   = 1'b1;
                hdr_info.is_long   = 1'b1;
                hdr_info.len_count = list_cnt[3:0];
            end
        endcase
    end

endmodule

FILE: hw/rtl/rlp_element_parser.sv
// RLP element parser. Bytes of an RLP message enter one per transfer on the
// s_ channel, with message_last set on the final byte, and every byte leaves
// on the m_ channel exactly once, tagged with its role, the kind of the
// top-level element it belongs to, an end-of-element flag and a malformed
// flag for a message that stops inside an element. A leading list header and
// its length bytes are tagged as the outer list and their length is not
// checked. The block sustains one byte per clock cycle with no bubbles
// between messages while the m_ channel is not stalled. A byte is held in
// the input register until the parse step can advance, and its result
// then moves into the result register and is offered on the m_ channel.
// The rate is set by the single parse step between the input register and
// the result register, whose longest path is the length accumulate or the
// remaining-byte decrement and its zero test, MAX_LENGTH_BYTES * 8 bits
// wide.
module rlp_element_parser
    import rlp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Width of the length accumulator and the remaining-byte counter.
    localparam int LEN_W = 8 * MAX_LENGTH_BYTES;

    // Parse phases.
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_OUTER_LEN = 3'd1;
    localparam logic [2:0] PH_HEADER    = 3'd2;
    localparam logic [2:0] PH_ELEM_LEN  = 3'd3;
    localparam logic [2:0] PH_BODY      = 3'd4;

    // Input register and result register.
    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;

    // Parser state.
    logic [2:0]       phase_reg,  phase_next;
    logic [LEN_W-1:0] left_reg,   left_next;
    logic [LEN_W-1:0] accum_reg,  accum_next;
    logic [3:0]       lcount_reg, lcount_next;
    logic [2:0]       kind_reg,   kind_next;

    logic       advance;
    logic [7:0] cur_byte;
    logic       cur_last;
    hdr_info_t  hdr_info;

    logic       take_hdr;
    logic [2:0] role;
    logic       elem_end;
    logic       bad;
    logic [LEN_W-1:0] accum_shift;
    logic [LEN_W-1:0] left_dec;
    logic [3:0]       lcount_dec;
    out_item_t        result;

    // The parse step runs when the held byte can move into the result
    // register: that register is empty or its transfer completes now.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign cur_byte = in_reg.data_byte;
    assign cur_last = in_reg.message_last;

    rlp_hdr_decode u_hdr_decode (
        .hdr_byte (cur_byte),
        .hdr_info (hdr_info)
    );

    assign accum_shift = (accum_reg << 8) | LEN_W'(cur_byte);
    assign left_dec    = left_reg - LEN_W'(1);
    assign lcount_dec  = lcount_reg - 4'd1;

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        accum_next  = accum_reg;
        lcount_next = lcount_reg;
        kind_next   = kind_reg;
        role        = ROLE_OUTER;
        elem_end    = 1'b0;
        take_hdr    = 1'b0;

        case (phase_reg)
            PH_START: begin
                // A list header at message start opens the outer list.
                if (cur_byte >= HDR_SHORT_LIST) begin
                    if (cur_byte >= HDR_LONG_LIST) begin
                        lcount_next = hdr_info.len_count;
                        phase_next  = PH_OUTER_LEN;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end else begin
                    take_hdr = 1'b1;
                end
            end
            PH_OUTER_LEN: begin
                lcount_next = lcount_dec;
                if (lcount_dec == 4'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_ELEM_LEN: begin
                role        = (kind_reg >= KIND_SHORT_LIST) ? ROLE_LIST : ROLE_LENGTH;
                accum_next  = accum_shift;
                lcount_next = lcount_dec;
                if (lcount_dec == 4'd0) begin
                    left_next = accum_shift;
                    if (accum_shift == '0) begin
                        elem_end   = 1'b1;
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                role      = (kind_reg >= KIND_SHORT_LIST) ? ROLE_LIST : ROLE_PAYLOAD;
                left_next = left_dec;
                if (left_dec == '0) begin
                    elem_end   = 1'b1;
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                take_hdr = 1'b1;
            end
        endcase

        // Element header: classify and load the length or the byte count.
        if (take_hdr) begin
            kind_next = hdr_info.kind;
            if (hdr_info.is_single) begin
                role       = ROLE_PAYLOAD;
                elem_end   = 1'b1;
                phase_next = PH_HEADER;
            end else begin
                role = hdr_info.is_list ? ROLE_LIST : ROLE_HEADER;
                if (hdr_info.is_long) begin
                    lcount_next = hdr_info.len_count;
                    accum_next  = '0;
                    phase_next  = PH_ELEM_LEN;
                end else begin
                    left_next = LEN_W'(hdr_info.short_len);
                    if (hdr_info.short_len == 6'd0) begin
                        elem_end   = 1'b1;
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
        end

        // A message that stops inside an element closes it as malformed.
        bad = cur_last && (phase_next == PH_ELEM_LEN || phase_next == PH_BODY);
        if (bad) begin
            elem_end = 1'b1;
        end

        result.out_byte     = cur_byte;
        result.byte_role    = role;
        result.element_kind = (role == ROLE_OUTER) ? KIND_SINGLE : kind_next;
        result.is_list      = (role != ROLE_OUTER) && (kind_next >= KIND_SHORT_LIST);
        result.element_end  = elem_end;
        result.malformed    = bad;
        result.message_end  = cur_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            left_reg      <= '0;
            accum_reg     <= '0;
            lcount_reg    <= 4'd0;
            kind_reg      <= KIND_SINGLE;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                // The end of a message returns every state to message start.
                if (cur_last) begin
                    phase_reg  <= PH_START;
                    left_reg   <= '0;
                    accum_reg  <= '0;
                    lcount_reg <= 4'd0;
                    kind_reg   <= KIND_SINGLE;
                end else begin
                    phase_reg  <= phase_next;
                    left_reg   <= left_next;
                    accum_reg  <= accum_next;
                    lcount_reg <= lcount_next;
                    kind_reg   <= kind_next;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule

FILE: hw/rtl/rlp_port_checker.sv
`include "assert_macros.svh"

module rlp_port_checker
    import rlp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic s_xfer;

    assign s_xfer = s_valid && s_ready;

    // A stalled input byte keeps its payload.
    `RLP_ASSERT_HOLD(a_s_hold, aclk, aresetn, s_valid, s_ready, s_data)

    // A stalled result keeps its payload.
    `RLP_ASSERT_HOLD(a_m_hold, aclk, aresetn, m_valid, m_ready, m_data)

    // Outer list bytes carry no element information.
    `RLP_ASSERT(a_outer_clean, aclk, aresetn, (m_valid && m_data.byte_role == ROLE_OUTER) |-> (m_data.element_kind == KIND_SINGLE && !m_data.is_list && !m_data.element_end && !m_data.malformed))

    // A malformed element only shows on the last byte, which also closes it.
    `RLP_ASSERT(a_bad_at_end, aclk, aresetn, (m_valid && m_data.malformed) |-> (m_data.message_end && m_data.element_end))

    // The list flag follows the element kind.
    `RLP_ASSERT(a_list_kind, aclk, aresetn, (m_valid && m_data.byte_role != ROLE_OUTER) |-> (m_data.is_list == (m_data.element_kind == KIND_SHORT_LIST || m_data.element_kind == KIND_LONG_LIST)))

    // With an empty pipeline, a byte taken in shows up as a valid result.
    `RLP_ASSERT(a_latency, aclk, aresetn, (s_xfer && !m_valid && $past(s_ready) && $past(!m_valid) && $past(aresetn)) |-> ##2 m_valid)

endmodule

bind rlp_element_parser rlp_port_checker u_rlp_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
